// ===== src/ofb_pkg.sv =====
package ofb_pkg;

  // Storage word and cell index geometry
  localparam int WORD_W = 32;
  localparam int WBIT_W = 5;
  localparam int IDX_W  = 14;
  localparam int WA_W   = IDX_W - WBIT_W;
  localparam int DIV_W  = 14;
  localparam int LIN_W  = 19;

  // Field widths
  localparam int DIM_W  = 7;
  localparam int ORG_W  = 8;
  localparam int POS_W  = 9;
  localparam int FREE_W = 13;
  localparam int OP_W   = 3;
  localparam int SIDX_W = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_ROW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_COL = 2'd3;

  localparam logic [DIM_W-1:0] ROWS_RST = 7'd32;
  localparam logic [DIM_W-1:0] COLS_RST = 7'd32;
  localparam logic [DIM_W-1:0] DIM_MIN  = 7'd3;

  localparam logic [FREE_W-1:0] FREE_MAX = '1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd0;
  localparam logic [OP_W-1:0] OP_MARK_OCC  = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND      = 3'd3;
  localparam logic [OP_W-1:0] OP_REINIT    = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [POS_W-1:0]  pos_row;
    logic [POS_W-1:0]  pos_col;
    logic [SIDX_W-1:0] start_index;
  } in_item_t;

  typedef struct packed {
    logic              occupied;
    logic              found_valid;
    logic [POS_W-1:0]  found_row;
    logic [POS_W-1:0]  found_col;
    logic [FREE_W-1:0] free_cells;
  } out_item_t;

endpackage

// ===== src/occupancy_bitmap_free_finder_top.sv =====
// Occupancy bitmap with free-cell search.
// Input: pulse start with in_data while busy is low; the operation is taken at
// that edge and busy stays high until its work is done. Every operation gives
// exactly one result: out_valid is high for one cycle with out_data, and the
// receiver must take it then (it cannot hold results off). A new operation may
// be started as soon as busy drops, while the previous result is on the port.
// Configuration: cfg_valid/cfg_ready write channel, always ready; write only
// while the block is idle. A new size or origin applies at once to addressing
// and search; the map layout follows it on the next reinit.
// Operations use the bitmap RAM (one read and one write port,
// 32 cells per word) and the shared 14-step shift-subtract divider:
//   query, mark occupied, mark free: a position outside the grid ends early.
//   find free: one division, a word scan, and a second division when a free
//     cell is found.
//   reinitialize: every map word is written, then the side cells one by one.
//   unused opcodes: result in the next cycle.
// Reset: the block runs the same reinitialize sweep, with the reset grid size,
// with busy high and no result.
module occupancy_bitmap_free_finder_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  ofb_pkg::in_item_t                in_data,
  output logic                             out_valid,
  output ofb_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ofb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ofb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WW      = ofb_pkg::WORD_W;
  localparam int BW      = ofb_pkg::WBIT_W;
  localparam int XW      = ofb_pkg::IDX_W;
  localparam int DW      = ofb_pkg::DIM_W;
  localparam int OW      = ofb_pkg::ORG_W;
  localparam int LW      = ofb_pkg::LIN_W;
  localparam int PW      = ofb_pkg::POS_W;
  localparam int FW      = ofb_pkg::FREE_W;
  localparam int CELLS   = MAX_ROWS * MAX_COLS;
  localparam int DEPTH   = (CELLS + WW - 1) / WW;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int CW      = (AW + BW > XW) ? AW + BW : XW;
  localparam int ROW_LIM = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam int COL_LIM = (MAX_COLS > 127) ? 127 : MAX_COLS;
  localparam logic [DW-1:0]    ROW_LIM_V = DW'(ROW_LIM);
  localparam logic [DW-1:0]    COL_LIM_V = DW'(COL_LIM);
  localparam logic [CNT_W-1:0] CELLS_V   = CNT_W'(CELLS);
  localparam logic [AW-1:0]    LAST_WORD = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOC,
    ST_CHK,
    ST_ACC,
    ST_MODW,
    ST_SCAN,
    ST_DIVW,
    ST_RI_SNAP,
    ST_RI_MUL,
    ST_RI_FILL,
    ST_RI_SRD,
    ST_RI_SWR
  } state_t;

  function automatic logic [DW-1:0] sat_dim(input logic [DW-1:0] v,
                                            input logic [DW-1:0] lim);
    logic [DW-1:0] r;
    r = v;
    if (v < ofb_pkg::DIM_MIN) begin
      r = ofb_pkg::DIM_MIN;
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

  function automatic logic [FW-1:0] sat_free(input logic [CNT_W-1:0] c);
    logic [FW-1:0] r;
    r = FW'(c);
    if (32'(c) > 32'(ofb_pkg::FREE_MAX)) begin
      r = ofb_pkg::FREE_MAX;
    end
    return r;
  endfunction

  // Configuration and derived geometry
  logic [DW-1:0] grid_rows_r;
  logic [DW-1:0] grid_cols_r;
  logic [OW-1:0] origin_row_r;
  logic [OW-1:0] origin_col_r;
  logic [DW-1:0] eff_rows_r;
  logic [DW-1:0] eff_cols_r;
  logic [XW-1:0] n_r;

  // Control and working registers
  state_t                state_r;
  ofb_pkg::in_item_t     item_r;
  logic signed [LW-1:0]  lin_r;
  logic                  out_valid_r;
  ofb_pkg::out_item_t    out_r;
  logic [CNT_W-1:0]      free_cnt_r;
  logic                  ri_emit_r;
  logic [DW-1:0]         rows_s_r;
  logic [DW-1:0]         cols_s_r;
  logic [XW-1:0]         bot_r;
  logic [XW-1:0]         ns_r;
  logic [AW-1:0]         fill_w_r;
  logic [XW-1:0]         side_p_r;
  logic                  side_t_r;

  // Combinational
  logic                  accept;
  logic signed [LW-1:0]  dr_x;
  logic signed [LW-1:0]  dc_x;
  logic signed [LW-1:0]  cols_x;
  logic signed [LW-1:0]  lin_nxt;
  logic                  in_grid;
  logic                  cur_bit;
  logic                  want_occ;
  logic [CNT_W-1:0]      free_nxt;
  logic                  emit;
  ofb_pkg::out_item_t    emit_item;
  logic [XW-1:0]         row_sum;
  logic [XW-1:0]         col_sum;
  logic [XW-1:0]         rows_x;
  logic [XW-1:0]         cols_sx;
  logic [WW-1:0]         fill_word;
  logic [CW-1:0]         fill_idx;

  // RAM, divider and scan connections
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [WW-1:0] ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [WW-1:0] ram_rd_data;
  logic          div_start;
  logic [XW-1:0] div_dividend;
  logic [XW-1:0] div_divisor;
  logic          div_done;
  logic [XW-1:0] div_quo;
  logic [XW-1:0] div_rem;
  logic          scan_go;
  logic          scan_rd_en;
  logic [AW-1:0] scan_rd_addr;
  logic          scan_done;
  logic          scan_found;
  logic [XW-1:0] scan_idx;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r  <= ofb_pkg::ROWS_RST;
      grid_cols_r  <= ofb_pkg::COLS_RST;
      origin_row_r <= '0;
      origin_col_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ofb_pkg::CFG_GRID_ROWS:  grid_rows_r  <= cfg_data[DW-1:0];
        ofb_pkg::CFG_GRID_COLS:  grid_cols_r  <= cfg_data[DW-1:0];
        ofb_pkg::CFG_ORIGIN_ROW: origin_row_r <= cfg_data[OW-1:0];
        ofb_pkg::CFG_ORIGIN_COL: origin_col_r <= cfg_data[OW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp grid size, then form the cell count
  assign rows_x = {{(XW - DW){1'b0}}, eff_rows_r};
  assign cols_sx = {{(XW - DW){1'b0}}, eff_cols_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_rows_r <= sat_dim(ofb_pkg::ROWS_RST, ROW_LIM_V);
      eff_cols_r <= sat_dim(ofb_pkg::COLS_RST, COL_LIM_V);
    end else begin
      eff_rows_r <= sat_dim(grid_rows_r, ROW_LIM_V);
      eff_cols_r <= sat_dim(grid_cols_r, COL_LIM_V);
    end
  end

  always_ff @(posedge clk) begin
    n_r <= rows_x * cols_sx;
  end

  // Linear index of the addressed position
  assign dr_x    = LW'($signed({1'b0, item_r.pos_row} - {2'b00, origin_row_r}));
  assign dc_x    = LW'($signed({1'b0, item_r.pos_col} - {2'b00, origin_col_r}));
  assign cols_x  = $signed({{(LW - DW){1'b0}}, eff_cols_r});
  assign lin_nxt = dr_x * cols_x + dc_x;
  assign in_grid = !lin_r[LW-1] && (lin_r[LW-2:XW] == '0) && (lin_r[XW-1:0] < n_r);

  assign cur_bit  = ram_rd_data[lin_r[BW-1:0]];
  assign want_occ = (item_r.opcode == ofb_pkg::OP_MARK_OCC);
  assign row_sum  = div_quo + {{(XW - OW){1'b0}}, origin_row_r};
  assign col_sum  = div_rem + {{(XW - OW){1'b0}}, origin_col_r};

  // Reinit word: top row and bottom row cells set, all else clear
  always_comb begin
    fill_word = '0;
    fill_idx  = '0;
    for (int b = 0; b < WW; b++) begin
      fill_idx     = CW'({fill_w_r, BW'(b)});
      fill_word[b] = (fill_idx < CW'(cols_s_r)) ||
                     ((fill_idx >= CW'(bot_r)) && (fill_idx < CW'(ns_r)));
    end
  end

  // Steer the RAM, the divider and the scan, and form results
  always_comb begin
    ram_wr_en    = 1'b0;
    ram_wr_addr  = AW'(lin_r[XW-1:BW]);
    ram_wr_data  = ram_rd_data;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = AW'(lin_r[XW-1:BW]);
    div_start    = 1'b0;
    div_dividend = XW'(item_r.start_index);
    div_divisor  = n_r;
    scan_go      = 1'b0;
    free_nxt     = free_cnt_r;
    emit         = 1'b0;
    emit_item    = '0;
    emit_item.free_cells = sat_free(free_cnt_r);
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.opcode > ofb_pkg::OP_REINIT)) begin
          emit = 1'b1;
        end
      end
      ST_CHK: begin
        if (item_r.opcode == ofb_pkg::OP_FIND) begin
          div_start = 1'b1;
        end else if (in_grid) begin
          ram_rd_en = 1'b1;
        end else begin
          emit               = 1'b1;
          emit_item.occupied = (item_r.opcode == ofb_pkg::OP_QUERY);
        end
      end
      ST_ACC: begin
        if (item_r.opcode != ofb_pkg::OP_QUERY) begin
          ram_wr_en                    = 1'b1;
          ram_wr_data[lin_r[BW-1:0]]   = want_occ;
          if (cur_bit != want_occ) begin
            if (want_occ && (free_cnt_r != '0)) begin
              free_nxt = free_cnt_r - 1'b1;
            end else if (!want_occ && (free_cnt_r < CELLS_V)) begin
              free_nxt = free_cnt_r + 1'b1;
            end
          end
        end
        emit                 = 1'b1;
        emit_item.occupied   = (item_r.opcode == ofb_pkg::OP_QUERY) && cur_bit;
        emit_item.free_cells = sat_free(free_nxt);
      end
      ST_MODW: begin
        scan_go = div_done;
      end
      ST_SCAN: begin
        ram_rd_en   = scan_rd_en;
        ram_rd_addr = scan_rd_addr;
        if (scan_done) begin
          if (scan_found) begin
            div_start    = 1'b1;
            div_dividend = scan_idx;
            div_divisor  = cols_sx;
          end else begin
            emit = 1'b1;
          end
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          emit                  = 1'b1;
          emit_item.found_valid = 1'b1;
          emit_item.found_row   = row_sum[PW-1:0];
          emit_item.found_col   = col_sum[PW-1:0];
        end
      end
      ST_RI_FILL: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = fill_w_r;
        ram_wr_data = fill_word;
      end
      ST_RI_SRD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = AW'(side_p_r[XW-1:BW]);
      end
      ST_RI_SWR: begin
        ram_wr_en                     = 1'b1;
        ram_wr_addr                   = AW'(side_p_r[XW-1:BW]);
        ram_wr_data[side_p_r[BW-1:0]] = 1'b1;
        if (side_t_r && (side_p_r == bot_r) && ri_emit_r) begin
          emit = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Sequence each operation; hold state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RI_SNAP;
      out_valid_r <= 1'b0;
      ri_emit_r   <= 1'b0;
      free_cnt_r  <= '0;
    end else begin
      out_valid_r <= emit;
      if (emit) begin
        out_r <= emit_item;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            item_r <= in_data;
            if (in_data.opcode == ofb_pkg::OP_REINIT) begin
              ri_emit_r <= 1'b1;
              state_r   <= ST_RI_SNAP;
            end else if (in_data.opcode < ofb_pkg::OP_REINIT) begin
              state_r <= ST_LOC;
            end
          end
        end
        ST_LOC: begin
          lin_r   <= lin_nxt;
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (item_r.opcode == ofb_pkg::OP_FIND) begin
            state_r <= ST_MODW;
          end else if (in_grid) begin
            state_r <= ST_ACC;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_ACC: begin
          free_cnt_r <= free_nxt;
          state_r    <= ST_IDLE;
        end
        ST_MODW: begin
          if (div_done) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_r <= scan_found ? ST_DIVW : ST_IDLE;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            state_r <= ST_IDLE;
          end
        end
        ST_RI_SNAP: begin
          rows_s_r <= eff_rows_r;
          cols_s_r <= eff_cols_r;
          state_r  <= ST_RI_MUL;
        end
        ST_RI_MUL: begin
          bot_r      <= XW'(rows_s_r - 1'b1) * XW'(cols_s_r);
          ns_r       <= XW'(rows_s_r) * XW'(cols_s_r);
          free_cnt_r <= CNT_W'(XW'(rows_s_r - 2'd2) * XW'(cols_s_r - 2'd2));
          fill_w_r   <= '0;
          state_r    <= ST_RI_FILL;
        end
        ST_RI_FILL: begin
          if (fill_w_r == LAST_WORD) begin
            side_p_r <= XW'(cols_s_r - 1'b1);
            side_t_r <= 1'b0;
            state_r  <= ST_RI_SRD;
          end else begin
            fill_w_r <= fill_w_r + 1'b1;
          end
        end
        ST_RI_SRD: begin
          state_r <= ST_RI_SWR;
        end
        ST_RI_SWR: begin
          // Side cells come in pairs: last of one row, first of the next
          if (side_t_r && (side_p_r == bot_r)) begin
            ri_emit_r <= 1'b0;
            state_r   <= ST_IDLE;
          end else begin
            side_p_r <= side_t_r ? side_p_r + XW'(cols_s_r) - XW'(1) : side_p_r + XW'(1);
            side_t_r <= !side_t_r;
            state_r  <= ST_RI_SRD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  ofb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ofb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ofb_scan #(
    .AW (AW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (scan_go),
    .start_idx (div_rem),
    .cell_cnt  (n_r),
    .rd_en     (scan_rd_en),
    .rd_addr   (scan_rd_addr),
    .rd_data   (ram_rd_data),
    .done      (scan_done),
    .found     (scan_found),
    .found_idx (scan_idx)
  );

endmodule

// ===== src/ofb_ram.sv =====
module ofb_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [ofb_pkg::WORD_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [ofb_pkg::WORD_W-1:0] rd_data
);

  logic [ofb_pkg::WORD_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/ofb_div.sv =====
module ofb_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ofb_pkg::DIV_W-1:0] dividend,
  input  logic [ofb_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [ofb_pkg::DIV_W-1:0] quotient,
  output logic [ofb_pkg::DIV_W-1:0] remainder
);

  localparam int DW    = ofb_pkg::DIV_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW:0]      rem_r;
  logic [DW-1:0]    quo_r;
  logic [DW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DW:0]      shifted;
  logic [DW:0]      trial;

  // One restoring step: shift in the next dividend bit and try the subtract
  assign shifted = {rem_r[DW-1:0], quo_r[DW-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      if (!trial[DW]) begin
        rem_r <= trial;
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[DW-1:0];

endmodule

// ===== src/ofb_scan.sv =====
module ofb_scan #(
  parameter int AW = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [ofb_pkg::IDX_W-1:0]  start_idx,
  input  logic [ofb_pkg::IDX_W-1:0]  cell_cnt,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  input  logic [ofb_pkg::WORD_W-1:0] rd_data,
  output logic                       done,
  output logic                       found,
  output logic [ofb_pkg::IDX_W-1:0]  found_idx
);

  localparam int WW = ofb_pkg::WORD_W;
  localparam int BW = ofb_pkg::WBIT_W;
  localparam int XW = ofb_pkg::IDX_W;
  localparam int VW = ofb_pkg::WA_W;

  // Issue side
  logic          iss_act_r;
  logic [VW-1:0] iss_w_r;
  logic          wrap_r;
  logic          first_r;
  logic          issue_last;

  // Scan bounds, held for the whole search
  logic [VW-1:0] ws_r;
  logic [VW-1:0] wl_r;
  logic [BW-1:0] off_r;
  logic [XW-1:0] cells_r;
  logic [XW-1:0] cnt_m1;

  // Check side: tag of the word whose data is on rd_data
  logic          tag_v_r;
  logic [VW-1:0] tag_w_r;
  logic          tag_first_r;
  logic          tag_last_r;

  logic [WW-1:0] free_bits;
  logic [XW-1:0] bit_idx;
  logic [BW-1:0] hit_pos;
  logic          hit;
  logic          stop;

  logic          done_r;
  logic          found_r;
  logic [XW-1:0] idx_r;

  assign cnt_m1     = cell_cnt - XW'(1);
  assign issue_last = wrap_r && (iss_w_r == ws_r);
  assign rd_en      = iss_act_r;
  assign rd_addr    = AW'(iss_w_r);

  // Free cells in the arriving word, lowest first
  always_comb begin
    free_bits = '0;
    hit_pos   = '0;
    bit_idx   = '0;
    for (int b = 0; b < WW; b++) begin
      bit_idx      = {tag_w_r, BW'(b)};
      free_bits[b] = !rd_data[b] && (bit_idx < cells_r) &&
                     (!tag_first_r || (BW'(b) >= off_r));
    end
    for (int b = WW - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit_pos = BW'(b);
      end
    end
  end

  assign hit  = |free_bits;
  assign stop = tag_v_r && (hit || tag_last_r);

  // Walk from the start word to the last word, then wrap to word 0 and go on up to the start word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_act_r <= 1'b0;
      tag_v_r   <= 1'b0;
      done_r    <= 1'b0;
      wrap_r    <= 1'b0;
      first_r   <= 1'b0;
      iss_w_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        iss_act_r <= 1'b1;
        iss_w_r   <= start_idx[XW-1:BW];
        wrap_r    <= 1'b0;
        first_r   <= 1'b1;
        tag_v_r   <= 1'b0;
      end else begin
        tag_v_r <= iss_act_r && !stop;
        if (stop) begin
          iss_act_r <= 1'b0;
          done_r    <= 1'b1;
        end else if (iss_act_r) begin
          first_r <= 1'b0;
          if (issue_last) begin
            iss_act_r <= 1'b0;
          end else if (iss_w_r == wl_r) begin
            iss_w_r <= '0;
            wrap_r  <= 1'b1;
          end else begin
            iss_w_r <= iss_w_r + 1'b1;
          end
        end
      end
    end
  end

  // Bounds, word tags and result
  always_ff @(posedge clk) begin
    if (go) begin
      ws_r    <= start_idx[XW-1:BW];
      wl_r    <= cnt_m1[XW-1:BW];
      off_r   <= start_idx[BW-1:0];
      cells_r <= cell_cnt;
    end
    tag_w_r     <= iss_w_r;
    tag_first_r <= first_r;
    tag_last_r  <= issue_last;
    if (stop) begin
      found_r <= hit;
      idx_r   <= {tag_w_r, hit_pos};
    end
  end

  assign done      = done_r;
  assign found     = found_r;
  assign found_idx = idx_r;

endmodule
